// ===== rtl/fsa_pkg.sv =====
// Shared types and constants for the fixed slot allocator.
package fsa_pkg;

	localparam int IDX_W   = 6;
	localparam int LIMIT_W = 7;

	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd64;

	typedef enum logic {
		OP_ALLOC = 1'b0,
		OP_FREE  = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		ST_OK          = 2'd0,
		ST_NONE_LEFT   = 2'd1,
		ST_DOUBLE_FREE = 2'd2,
		ST_NEVER_GIVEN = 2'd3
	} status_t;

	typedef struct packed {
		op_t              op;
		logic [IDX_W-1:0] slot_index;
	} req_t;

	typedef struct packed {
		logic [IDX_W-1:0] given_slot;
		status_t          status;
	} rsp_t;

endpackage

// ===== rtl/fsa_if.sv =====
// Valid/ready channel interfaces: request, response and limit register write.
interface fsa_req_if;
	logic                     valid;
	logic                     ready;
	fsa_pkg::op_t             op;
	logic [fsa_pkg::IDX_W-1:0] slot_index;

	modport source (output valid, op, slot_index, input ready);
	modport sink   (input valid, op, slot_index, output ready);
endinterface

interface fsa_rsp_if;
	logic                     valid;
	logic                     ready;
	logic [fsa_pkg::IDX_W-1:0] given_slot;
	fsa_pkg::status_t         status;

	modport source (output valid, given_slot, status, input ready);
	modport sink   (input valid, given_slot, status, output ready);
endinterface

interface fsa_cfg_if;
	logic                       valid;
	logic                       ready;
	logic [fsa_pkg::LIMIT_W-1:0] slot_limit;

	modport source (output valid, slot_limit, input ready);
	modport sink   (input valid, slot_limit, output ready);
endinterface

// ===== rtl/fsa_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module fsa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== rtl/fsa_core.sv =====
// Allocator state: free list head, link RAM, free bitmap and bump counter.
module fsa_core #(
	parameter int SLOTS = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          fire,
	input  fsa_pkg::req_t                 req,
	input  logic [fsa_pkg::LIMIT_W-1:0]   limit,
	output fsa_pkg::rsp_t                 rsp
);

	localparam int LW = $clog2(SLOTS);
	localparam int CW = $clog2(SLOTS + 1);
	localparam int EW = (CW > fsa_pkg::LIMIT_W) ? CW : fsa_pkg::LIMIT_W;
	localparam logic [EW-1:0] SLOTS_E = EW'(SLOTS);

	logic [LW-1:0]    head_q;
	logic             empty_q;
	logic [CW-1:0]    bump_q;
	logic [SLOTS-1:0] mark_q;
	logic [LW-1:0]    head_next_q;
	logic             nx_pend_q;

	logic [LW-1:0] ram_rdata;
	logic [LW-1:0] head_next;
	logic [LW-1:0] idx_l;
	logic [LW-1:0] push_link;
	logic [EW-1:0] bump_e;
	logic [EW-1:0] idx_e;
	logic          do_pop;
	logic          do_bump;
	logic          do_push;

	// link of the current head: fresh from RAM the beat after a pop
	assign head_next = nx_pend_q ? ram_rdata : head_next_q;
	assign idx_l     = LW'(req.slot_index);
	assign push_link = empty_q ? idx_l : head_q;
	assign bump_e    = EW'(bump_q);
	assign idx_e     = EW'(req.slot_index);

	always_comb begin
		do_pop  = 1'b0;
		do_bump = 1'b0;
		do_push = 1'b0;
		rsp.given_slot = '0;
		rsp.status     = fsa_pkg::ST_OK;
		case (req.op)
			fsa_pkg::OP_ALLOC: begin
				if (!empty_q) begin
					do_pop = 1'b1;
					rsp.given_slot = fsa_pkg::IDX_W'(head_q);
				end else if (bump_e < EW'(limit) && bump_e < SLOTS_E) begin
					do_bump = 1'b1;
					rsp.given_slot = fsa_pkg::IDX_W'(bump_q);
				end else begin
					rsp.status = fsa_pkg::ST_NONE_LEFT;
				end
			end
			fsa_pkg::OP_FREE: begin
				if (!(idx_e < bump_e)) begin
					rsp.status = fsa_pkg::ST_NEVER_GIVEN;
				end else if (mark_q[idx_l]) begin
					rsp.status = fsa_pkg::ST_DOUBLE_FREE;
				end else begin
					do_push = 1'b1;
				end
			end
			default: begin
				rsp.status = fsa_pkg::ST_OK;
			end
		endcase
	end

	fsa_ram #(
		.WIDTH (LW),
		.DEPTH (SLOTS)
	) u_link_ram (
		.clk   (clk),
		.we    (fire && do_push),
		.waddr (idx_l),
		.wdata (push_link),
		.raddr (head_next),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q    <= '0;
			empty_q   <= 1'b1;
			bump_q    <= '0;
			mark_q    <= '0;
			nx_pend_q <= 1'b0;
		end else begin
			nx_pend_q <= fire && do_pop && (head_next != head_q);
			if (fire && do_pop) begin
				mark_q[head_q] <= 1'b0;
				if (head_next == head_q) begin
					empty_q <= 1'b1;
				end else begin
					head_q <= head_next;
				end
			end
			if (fire && do_bump) begin
				bump_q <= bump_q + CW'(1);
			end
			if (fire && do_push) begin
				mark_q[idx_l] <= 1'b1;
				head_q        <= idx_l;
				empty_q       <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire && do_push) begin
			head_next_q <= push_link;
		end else begin
			head_next_q <= head_next;
		end
	end

endmodule

// ===== rtl/fixed_slot_allocator.sv =====
// Fixed slot allocator top level: request register, allocator core, response register.
//
// Channels: req (op, slot_index) in, rsp (given_slot, status) out, cfg
// writes the 7-bit slot_limit; cfg is always ready and takes effect on the
// next request processed. Write it only while no request is outstanding.
// A request beat is captured in an input register; when the response register
// is free or being drained the core resolves it in one pass (pop free list,
// bump counter or push) and the result lands in the response register, which
// drives rsp.valid. One request per cycle is sustained unless rsp stalls;
// the link of the current list head is kept in a register, refreshed from the
// link RAM's registered read port the cycle after each pop.
// When rsp is stalled the response register holds, the input register keeps
// its request and req.ready drops only once both are full.
// Reset (arst_n low) empties the free list, clears the free bitmap and bump
// counter and sets slot_limit to 64; link RAM contents are not cleared.
module fixed_slot_allocator #(
	parameter int SLOTS = 64
) (
	input  logic     clk,
	input  logic     arst_n,
	fsa_cfg_if.sink  cfg,
	fsa_req_if.sink  req,
	fsa_rsp_if.source rsp
);

	logic                        valid_s1;
	fsa_pkg::req_t               req_s1;
	logic                        rsp_valid_q;
	fsa_pkg::rsp_t               rsp_q;
	logic [fsa_pkg::LIMIT_W-1:0] limit_q;
	fsa_pkg::rsp_t               core_rsp;
	logic                        advance;

	assign advance    = valid_s1 && (!rsp_valid_q || rsp.ready);
	assign req.ready  = !valid_s1 || advance;
	assign cfg.ready  = 1'b1;
	assign rsp.valid      = rsp_valid_q;
	assign rsp.given_slot = rsp_q.given_slot;
	assign rsp.status     = rsp_q.status;

	fsa_core #(
		.SLOTS (SLOTS)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (advance),
		.req    (req_s1),
		.limit  (limit_q),
		.rsp    (core_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			rsp_valid_q <= 1'b0;
			limit_q     <= fsa_pkg::LIMIT_RESET;
		end else begin
			if (req.valid && req.ready) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			if (cfg.valid) begin
				limit_q <= cfg.slot_limit;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			req_s1.op         <= req.op;
			req_s1.slot_index <= req.slot_index;
		end
		if (advance) begin
			rsp_q <= core_rsp;
		end
	end

endmodule

// ===== rtl/fsa_checker.sv =====
// Port-level checks for the fixed slot allocator, bound to the top level.
module fsa_checker (
	input logic       clk,
	input logic       arst_n,
	fsa_cfg_if.sink   cfg,
	fsa_req_if.sink   req,
	fsa_rsp_if.source rsp
);

	logic [1:0] pend_q;
	logic       req_beat;
	logic       rsp_beat;

	assign req_beat = req.valid && req.ready;
	assign rsp_beat = rsp.valid && rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else begin
			pend_q <= pend_q + 2'(req_beat) - 2'(rsp_beat);
		end
	end

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.given_slot)
			&& $stable(rsp.status))
		else $error("response changed while stalled");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.status != fsa_pkg::ST_OK |-> rsp.given_slot == '0)
		else $error("failed beat carries a slot");

	a_no_orphan: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> pend_q != 2'd0)
		else $error("response without request");

	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q != 2'd3 && (pend_q != 2'd2 || !req.ready || rsp.ready))
		else $error("more than two requests in flight");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!req.ready |-> rsp.valid && !rsp.ready && cfg.ready)
		else $error("request stalled with output free");

endmodule

bind fixed_slot_allocator fsa_checker u_fsa_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.cfg    (cfg),
	.req    (req),
	.rsp    (rsp)
);
